// ===== design/ept_pw_pkg.sv =====
// ----------------------------------------------------------------------------
// ept_pw_pkg
// Shared types, codes and constants of the EPT page walker.
// ----------------------------------------------------------------------------
package ept_pw_pkg;

  // Default physical address width of the host.
  localparam int PHYS_ADDR_BITS_DEF = 52;

  // Depth of the result queue; two slots are kept free to take an item.
  localparam int RES_DEPTH = 4;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_PERMIT    = 2'd1;
  localparam logic [1:0] OP_ENTRY     = 2'd2;

  // Kinds of result.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Finish status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] ST_BUSY        = 2'd2;

  // Walk levels.
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] guest_address;
    logic        grant_read;
    logic        grant_write;
    logic        grant_execute;
    logic [63:0] entry_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [51:0] mem_address;
    logic [63:0] write_word;
    logic [1:0]  status;
    logic [51:0] host_address;
    logic        last;
  } out_item_t;

  // Walk context kept between requests and entry responses.
  typedef struct packed {
    logic        busy;
    logic        update;
    logic [1:0]  level;
    logic [47:0] gaddr;
    logic [2:0]  grants;
    logic [51:0] pend_addr;
  } walk_state_t;

endpackage

// ===== design/ept_pw_walk.sv =====
// ----------------------------------------------------------------------------
// ept_pw_walk
// One step of the walk: from the current context and one input item, the
// next context and up to two results.
// ----------------------------------------------------------------------------
module ept_pw_walk #(
  parameter int PHYS_ADDR_BITS = ept_pw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  ept_pw_pkg::in_item_t    item,
  input  ept_pw_pkg::walk_state_t st,
  input  logic [39:0]             root_frame,
  output ept_pw_pkg::walk_state_t st_nxt,
  output ept_pw_pkg::out_item_t   res0,
  output ept_pw_pkg::out_item_t   res1,
  output logic [1:0]              n_res
);

  // Physical address masks, with the frame bits at and above a page size.
  localparam logic [51:0] TOP_MASK = {52{1'b1}} >> (52 - PHYS_ADDR_BITS);
  localparam logic [51:0] LOW12    = (52'(1) << 12) - 52'(1);
  localparam logic [51:0] LOW21    = (52'(1) << 21) - 52'(1);
  localparam logic [51:0] LOW30    = (52'(1) << 30) - 52'(1);
  localparam logic [51:0] FRAME12  = TOP_MASK & ~LOW12;
  localparam logic [51:0] FRAME21  = TOP_MASK & ~LOW21;
  localparam logic [51:0] FRAME30  = TOP_MASK & ~LOW30;

  // Address of the entry for a level within a table.
  function automatic logic [51:0] slot_addr(input logic [51:0] base,
                                            input logic [47:0] ga,
                                            input logic [1:0]  lvl);
    logic [8:0] idx;
    begin
      case (lvl)
        ept_pw_pkg::LVL_PML4: idx = ga[47:39];
        ept_pw_pkg::LVL_PDPT: idx = ga[38:30];
        ept_pw_pkg::LVL_PD:   idx = ga[29:21];
        default:              idx = ga[20:12];
      endcase
      slot_addr = (base & FRAME12) | {40'd0, idx, 3'd0};
    end
  endfunction

  logic        present;
  logic        leaf;
  logic [1:0]  next_level;
  logic [51:0] frame_mask;
  logic [51:0] host;
  logic [51:0] next_slot;
  logic [47:0] req_ga;

  // Leaf test, translated address and next entry address.
  always_comb begin
    present    = (item.entry_word[2:0] != 3'd0);
    leaf       = (st.level == ept_pw_pkg::LVL_PT) ||
                 (((st.level == ept_pw_pkg::LVL_PDPT) || (st.level == ept_pw_pkg::LVL_PD))
                  && item.entry_word[7]);
    next_level = st.level + 2'd1;
    case (st.level)
      ept_pw_pkg::LVL_PDPT: frame_mask = FRAME30;
      ept_pw_pkg::LVL_PD:   frame_mask = FRAME21;
      default:              frame_mask = FRAME12;
    endcase
    // The page offset is only the guest bits below the page size.
    host      = (item.entry_word[51:0] & frame_mask) |
                ({4'd0, st.gaddr} & ~frame_mask & TOP_MASK);
    next_slot = slot_addr(item.entry_word[51:0], st.gaddr, next_level);
    req_ga    = item.guest_address;
  end

  // Step decode.
  always_comb begin
    st_nxt = st;
    res0   = '0;
    res1   = '0;
    n_res  = 2'd0;
    case (item.operation)
      ept_pw_pkg::OP_TRANSLATE, ept_pw_pkg::OP_PERMIT: begin
        n_res     = 2'd1;
        res0.last = 1'b1;
        if (st.busy) begin
          res0.kind   = ept_pw_pkg::KIND_DONE;
          res0.status = ept_pw_pkg::ST_BUSY;
        end else begin
          st_nxt.busy      = 1'b1;
          st_nxt.update    = (item.operation == ept_pw_pkg::OP_PERMIT);
          st_nxt.level     = ept_pw_pkg::LVL_PML4;
          st_nxt.gaddr     = req_ga;
          st_nxt.grants    = {item.grant_execute, item.grant_write, item.grant_read};
          st_nxt.pend_addr = slot_addr({root_frame, 12'd0}, req_ga, ept_pw_pkg::LVL_PML4);
          res0.kind        = ept_pw_pkg::KIND_READ;
          res0.mem_address = st_nxt.pend_addr;
        end
      end
      ept_pw_pkg::OP_ENTRY: begin
        if (st.busy) begin
          if (!present) begin
            // Missing entry ends the walk.
            st_nxt.busy = 1'b0;
            n_res       = 2'd1;
            res0.kind   = ept_pw_pkg::KIND_DONE;
            res0.status = ept_pw_pkg::ST_NOT_PRESENT;
            res0.last   = 1'b1;
          end else if (leaf) begin
            st_nxt.busy = 1'b0;
            if (st.update) begin
              n_res            = 2'd2;
              res0.kind        = ept_pw_pkg::KIND_WRITE;
              res0.mem_address = st.pend_addr;
              res0.write_word  = {item.entry_word[63:3], st.grants};
              res1.kind        = ept_pw_pkg::KIND_DONE;
              res1.last        = 1'b1;
            end else begin
              n_res             = 2'd1;
              res0.kind         = ept_pw_pkg::KIND_DONE;
              res0.host_address = host;
              res0.last         = 1'b1;
            end
          end else begin
            // Intermediate entry: optional write-back, then the next read.
            st_nxt.level     = next_level;
            st_nxt.pend_addr = next_slot;
            if (st.update) begin
              n_res            = 2'd2;
              res0.kind        = ept_pw_pkg::KIND_WRITE;
              res0.mem_address = st.pend_addr;
              res0.write_word  = item.entry_word | {61'd0, st.grants};
              res1.kind        = ept_pw_pkg::KIND_READ;
              res1.mem_address = next_slot;
              res1.last        = 1'b1;
            end else begin
              n_res            = 2'd1;
              res0.kind        = ept_pw_pkg::KIND_READ;
              res0.mem_address = next_slot;
              res0.last        = 1'b1;
            end
          end
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

endmodule

// ===== design/ept_pw_fifo.sv =====
// ----------------------------------------------------------------------------
// ept_pw_fifo
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ept_pw_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_n,
  input  ept_pw_pkg::out_item_t push_d0,
  input  ept_pw_pkg::out_item_t push_d1,
  output logic                  space_ok,
  output logic [$clog2(ept_pw_pkg::RES_DEPTH):0] count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ept_pw_pkg::out_item_t out_data
);

  localparam int PW = $clog2(ept_pw_pkg::RES_DEPTH);

  ept_pw_pkg::out_item_t mem [ept_pw_pkg::RES_DEPTH];

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;

  // Pointer and fill arithmetic.
  always_comb begin
    pop       = out_valid && out_ready;
    wp_nxt    = wp_r + PW'(push_n);
    rp_nxt    = rp_r + PW'(pop);
    count_nxt = count_r + (PW + 1)'(push_n) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage writes, one or two slots in order.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + PW'(1)] <= push_d1;
    end
  end

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rp_r];
  assign space_ok  = (count_r <= (PW + 1)'(ept_pw_pkg::RES_DEPTH - 2));
  assign count     = count_r;

endmodule

// ===== design/ept_pw_core.sv =====
// ----------------------------------------------------------------------------
// ept_page_walker_core
// Four-level EPT walker: requests and entry responses in, entry reads,
// entry writes and finish results out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | in_data   (in_item_t)
//  out_    | output    | out_valid/out_ready | out_data  (out_item_t)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data  (root table frame)
//
// Each input transfer is decoded in the cycle it is taken, and its results,
// none, one or two, enter a four-slot result queue and are held from the next cycle.
// One input item a cycle is taken while the queue has two free slots; results
// leave one per cycle, so the output side sets the rate for two-result items.
// Reset is synchronous and clears the walk context, the root frame and the
// queue; there is no clearing pass. The configuration port is always ready.
// ----------------------------------------------------------------------------
module ept_page_walker_core #(
  parameter int PHYS_ADDR_BITS = ept_pw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ept_pw_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ept_pw_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [39:0]           cfg_data
);

  ept_pw_pkg::walk_state_t state_r, state_nxt;
  ept_pw_pkg::out_item_t   res0, res1;
  logic [39:0]             root_r;
  logic [1:0]              n_res;
  logic [1:0]              push_n;
  logic                    in_fire;
  logic                    space_ok;
  logic [$clog2(ept_pw_pkg::RES_DEPTH):0] q_count;

  assign in_ready  = space_ok;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign push_n    = in_fire ? n_res : 2'd0;

  // Root table frame register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_r <= cfg_data;
    end
  end

  // Walk context, advanced on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  ept_pw_walk #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_walk (
    .item       (in_data),
    .st         (state_r),
    .root_frame (root_r),
    .st_nxt     (state_nxt),
    .res0       (res0),
    .res1       (res1),
    .n_res      (n_res)
  );

  ept_pw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_d0   (res0),
    .push_d1   (res1),
    .space_ok  (space_ok),
    .count     (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(ept_pw_pkg::RES_DEPTH) + 1)'(ept_pw_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  // A request taken while idle starts a walk.
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !state_r.busy &&
    (in_data.operation == ept_pw_pkg::OP_TRANSLATE ||
     in_data.operation == ept_pw_pkg::OP_PERMIT)
    |=> state_r.busy)
    else $error("request did not start a walk");

  // A request refused while busy leaves the walk context untouched.
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && state_r.busy &&
    (in_data.operation == ept_pw_pkg::OP_TRANSLATE ||
     in_data.operation == ept_pw_pkg::OP_PERMIT)
    |=> state_r == $past(state_r))
    else $error("refused request changed the walk");

  // An item that produces results always places at least one in the queue.
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |=> out_valid)
    else $error("results lost from the queue");
`endif

endmodule

// ===== test/tb_ept_page_walker_core.sv =====
// ----------------------------------------------------------------------------
// tb_ept_page_walker_core
// Self-checking bench for the four-level EPT walker. Directed walks cover
// every leaf size, both request types, missing entries, busy refusals and
// ignored items. Long runs of random walks follow, under several root table
// frames. A scoreboard predicts every entry read, entry write and finish
// result and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ept_page_walker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ept_pw_pkg::*;

  localparam int PA_BITS = PHYS_ADDR_BITS_DEF;

  // Operation code that the walker ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SETTLE_WAIT  = 8;
  localparam int unsigned END_WAIT     = 20;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TOTAL_ITEMS  = 1400;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the walk context and the root frame,
  // and holds the results that the walker still owes.
  // --------------------------------------------------------------------------
  class walk_scoreboard;
    logic [39:0] root_frame;
    logic        walk_busy;
    logic        update_mode;
    logic [1:0]  walk_level;
    logic [47:0] held_ga;
    logic [2:0]  held_grants;
    logic [51:0] pend_addr;

    out_item_t   owed_results[$];

    int unsigned mismatches;
    int unsigned received;
    int unsigned walks_ok;
    int unsigned walks_missing;
    int unsigned refusals;

    function new();
      root_frame    = '0;
      walk_busy     = 1'b0;
      update_mode   = 1'b0;
      walk_level    = LVL_PML4;
      held_ga       = '0;
      held_grants   = '0;
      pend_addr     = '0;
      mismatches    = 0;
      received      = 0;
      walks_ok      = 0;
      walks_missing = 0;
      refusals      = 0;
    endfunction

    function void set_root(logic [39:0] frame);
      root_frame = frame;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Address bits from PA_BITS-1 down to low_bit.
    function logic [51:0] phys_mask(int low_bit);
      logic [51:0] m;
      m = '0;
      for (int b = low_bit; b < PA_BITS; b++) m[b] = 1'b1;
      return m;
    endfunction

    // Byte address of the entry that the held guest address selects.
    function logic [51:0] slot_address(logic [51:0] table_base, logic [1:0] lvl);
      int         shift;
      logic [8:0] idx;
      shift = 39 - 9 * int'(lvl);
      idx   = 9'(held_ga >> shift);
      return (table_base & phys_mask(12)) | {40'b0, idx, 3'b000};
    endfunction

    function void owe(logic [1:0] kind, logic [51:0] addr, logic [63:0] word,
                      logic [1:0] status, logic [51:0] host, logic last);
      out_item_t r;
      r.kind         = kind;
      r.mem_address  = addr;
      r.write_word   = word;
      r.status       = status;
      r.host_address = host;
      r.last         = last;
      owed_results.push_back(r);
    endfunction

    // Works out what one accepted input transfer makes the walker emit.
    function void predict_item(in_item_t it);
      logic [63:0] entry;
      logic [1:0]  lvl;
      logic        leaf;
      int          low_bit;
      logic [51:0] low_mask;
      logic [51:0] host;
      if (it.operation == OP_TRANSLATE || it.operation == OP_PERMIT) begin
        if (walk_busy) begin
          refusals++;
          owe(KIND_DONE, '0, '0, ST_BUSY, '0, 1'b1);
        end else begin
          walk_busy   = 1'b1;
          update_mode = (it.operation == OP_PERMIT);
          walk_level  = LVL_PML4;
          held_ga     = it.guest_address;
          held_grants = {it.grant_execute, it.grant_write, it.grant_read};
          pend_addr   = slot_address({root_frame, 12'b0}, LVL_PML4);
          owe(KIND_READ, pend_addr, '0, ST_OK, '0, 1'b1);
        end
        return;
      end
      if (it.operation != OP_ENTRY || !walk_busy) return;

      entry = it.entry_word;
      lvl   = walk_level;

      // A missing entry ends the walk with nothing written.
      if (entry[2:0] == 3'b000) begin
        walk_busy = 1'b0;
        walks_missing++;
        owe(KIND_DONE, '0, '0, ST_NOT_PRESENT, '0, 1'b1);
        return;
      end

      leaf = (lvl == LVL_PT) || ((lvl == LVL_PDPT || lvl == LVL_PD) && entry[7]);

      if (leaf) begin
        host = '0;
        if (update_mode) begin
          owe(KIND_WRITE, pend_addr, (entry & ~64'h7) | {61'b0, held_grants},
              ST_OK, '0, 1'b0);
        end else begin
          low_bit  = (lvl == LVL_PDPT) ? 30 : (lvl == LVL_PD) ? 21 : 12;
          low_mask = (52'd1 << low_bit) - 52'd1;
          host     = (entry[51:0] & phys_mask(low_bit)) | ({4'b0, held_ga} & low_mask);
        end
        walk_busy = 1'b0;
        walks_ok++;
        owe(KIND_DONE, '0, '0, ST_OK, host, 1'b1);
        return;
      end

      // Intermediate level: optional write-back, then read the next table.
      if (update_mode) begin
        owe(KIND_WRITE, pend_addr, entry | {61'b0, held_grants}, ST_OK, '0, 1'b0);
      end
      walk_level = lvl + 2'd1;
      pend_addr  = slot_address(entry[51:0], walk_level);
      owe(KIND_READ, pend_addr, '0, ST_OK, '0, 1'b1);
    endfunction

    // Compares one result transfer with the oldest owed result.
    function void check_result(out_item_t got);
      out_item_t want;
      received++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: result with nothing owed: kind %0d mem %h word %h status %0d host %h last %b",
                   got.kind, got.mem_address, got.write_word, got.status,
                   got.host_address, got.last);
        end
        return;
      end
      want = owed_results.pop_front();
      if (got.kind !== want.kind || got.mem_address !== want.mem_address ||
          got.write_word !== want.write_word || got.status !== want.status ||
          got.host_address !== want.host_address || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: result %0d differs", received);
          $display("  expected kind %0d mem %h word %h status %0d host %h last %b",
                   want.kind, want.mem_address, want.write_word, want.status,
                   want.host_address, want.last);
          $display("  actual   kind %0d mem %h word %h status %0d host %h last %b",
                   got.kind, got.mem_address, got.write_word, got.status,
                   got.host_address, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block under test.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [39:0] cfg_data;

  walk_scoreboard sb;

  int unsigned items_sent;
  int unsigned root_settings;
  int unsigned cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_off_req;

  ept_page_walker_core #(
    .PHYS_ADDR_BITS(PA_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: run stopped after %0d cycles with %0d results owed",
             cycle_count, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: checks every transfer and, when enabled, stalls in random
  // bursts, with one long hold-off on request so that the walker backs up
  // onto its input.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item builders.
  // --------------------------------------------------------------------------
  function automatic in_item_t mk_request(logic [1:0] op, logic [47:0] ga,
                                          logic [2:0] grants);
    in_item_t it;
    it               = '0;
    it.operation     = op;
    it.guest_address = ga;
    {it.grant_execute, it.grant_write, it.grant_read} = grants;
    return it;
  endfunction

  function automatic in_item_t mk_entry(logic [63:0] word);
    in_item_t it;
    it            = '0;
    it.operation  = OP_ENTRY;
    it.entry_word = word;
    return it;
  endfunction

  // Every field random; callers then fix the operation.
  function automatic in_item_t random_fields();
    in_item_t it;
    it.operation     = 2'($urandom_range(0, 3));
    it.guest_address = {16'($urandom), $urandom};
    it.grant_read    = 1'($urandom);
    it.grant_write   = 1'($urandom);
    it.grant_execute = 1'($urandom);
    it.entry_word    = {$urandom, $urandom};
    return it;
  endfunction

  // An entry word for the given level: mostly present, large pages now and then.
  function automatic in_item_t random_entry(logic [1:0] lvl);
    in_item_t it;
    it           = random_fields();
    it.operation = OP_ENTRY;
    if ($urandom_range(0, 99) < 7) begin
      it.entry_word[2:0] = 3'b000;
    end else if (it.entry_word[2:0] == 3'b000) begin
      it.entry_word[2:0] = 3'($urandom_range(1, 7));
    end
    if (lvl == LVL_PDPT || lvl == LVL_PD) begin
      it.entry_word[7] = ($urandom_range(0, 3) == 0);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.predict_item(it);
    items_sent++;
  endtask

  // Stops offering items until every owed result has come, then settles.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_root(input logic [39:0] frame);
    cfg_valid <= 1'b1;
    cfg_data  <= frame;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_root(frame);
    root_settings++;
  endtask

  // One random walk, carried on until the walker is idle again; now and
  // then a stray request or an ignored item is slipped in.
  task automatic run_walk();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it           = random_fields();
      it.operation = (pick < 2) ? OP_ENTRY : OP_UNUSED;
      send_item(it);
      return;
    end
    it           = random_fields();
    it.operation = $urandom_range(0, 1) ? OP_PERMIT : OP_TRANSLATE;
    send_item(it);
    while (sb.walk_busy) begin
      if ($urandom_range(0, 99) < 6) begin
        it = random_fields();
        if (it.operation == OP_ENTRY) it.operation = OP_UNUSED;
        send_item(it);
      end
      send_item(random_entry(sb.walk_level));
    end
  endtask

  task automatic run_phase(input logic [39:0] frame, input bit tx_idle,
                           input bit rx_idle, input int unsigned upto,
                           input bit with_hold);
    int unsigned start;
    bit          hold_sent;
    drain();
    write_root(frame);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    start      = items_sent;
    hold_sent  = 1'b0;
    while (items_sent < upto) begin
      if (with_hold && !hold_sent && items_sent >= start + 100) begin
        hold_off_req = 1'b1;
        hold_sent    = 1'b1;
      end
      run_walk();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb            = new();
    items_sent    = 0;
    root_settings = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_off_req  = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Translate at the top of the address space, ending on a 1 GiB page.
    send_item(mk_request(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 3'b000));
    send_item(mk_entry(64'hFFFF_FFFF_FFFF_FFFF));
    send_item(mk_entry(64'hFFFF_FFFF_FFFF_FFFF));
    // Permission walk with no grants, ending on a 2 MiB page.
    send_item(mk_request(OP_PERMIT, 48'h0000_0000_0000, 3'b000));
    send_item(mk_entry(64'h0000_0000_0000_0001));
    send_item(mk_entry(64'h0000_0000_0000_0002));
    send_item(mk_entry(64'h0000_0000_0000_0084));
    // Permission walk with every grant, down to a 4 KiB page.
    send_item(mk_request(OP_PERMIT, 48'h5A5A_A5A5_3C3C, 3'b111));
    send_item(mk_entry(64'h000F_FFFF_FFFF_F003));
    send_item(mk_entry(64'hFFF0_0000_0000_0005));
    send_item(mk_entry(64'h8000_1234_5678_9006));
    send_item(mk_entry(64'h0000_000A_BCDE_F087));
    // Translate with a refused request and an ignored item part-way through.
    send_item(mk_request(OP_TRANSLATE, 48'h0000_8040_2010, 3'b000));
    send_item(mk_entry(64'h0000_0000_0000_0007));
    send_item(mk_request(OP_PERMIT, 48'hFFFF_FFFF_FFFF, 3'b111));
    send_item(mk_entry(64'h0000_0000_0040_0003));
    send_item(mk_request(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 3'b111));
    send_item(mk_entry(64'h0000_0000_0080_0001));
    send_item(mk_entry(64'h000F_FFFF_FFFF_F004));
    // Top-level entry missing.
    send_item(mk_request(OP_TRANSLATE, 48'h1234_5678_9ABC, 3'b000));
    send_item(mk_entry(64'hFFFF_FFFF_FFFF_FFF8));
    // Entry word and unused operation while idle.
    send_item(mk_entry(64'hFFFF_FFFF_FFFF_FFFF));
    send_item(mk_request(OP_UNUSED, 48'h0, 3'b000));

    // Random walks under several root frames; the last stretch runs flat out.
    run_phase(40'hFF_FFFF_FFFF, 1'b1, 1'b1, 320, 1'b0);
    run_phase(40'h00_0000_0000, 1'b0, 1'b1, 620, 1'b0);
    run_phase(40'({$urandom, $urandom}), 1'b1, 1'b1, 920, 1'b1);
    run_phase(40'({$urandom, $urandom}), 1'b1, 1'b0, 1200, 1'b0);
    run_phase(40'({$urandom, $urandom}), 1'b0, 1'b0, TOTAL_ITEMS, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.mismatches++;
      $display("ERROR: %0d results never arrived", sb.pending());
    end
    $display("Run covered %0d input transfers and %0d result transfers under %0d root frames.",
             items_sent, sb.received, root_settings + 1);
    $display("Walks: %0d completed, %0d stopped at a missing entry, %0d requests refused.",
             sb.walks_ok, sb.walks_missing, sb.refusals);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Failures: %0d", sb.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
